// File: src/wrrs_pkg.sv
// Shared types and constants of the weighted round-robin scheduler.
package wrrs_pkg;

    localparam int QUEUE_DEPTH_DEFAULT = 16;
    localparam logic [15:0] QUANTUM_RESET = 16'd10;
    localparam int OCC_W = 5;

    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_SLICE = 1'b1;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic        operation;
        logic [7:0]  task_id;
        logic [15:0] arrival;
        logic [15:0] burst;
        logic [1:0]  task_class;
    } item_t;

    // One queue slot as held in the record RAM.
    typedef struct packed {
        logic [7:0]  id;
        logic [15:0] arrival;
        logic [15:0] remaining;
        logic [1:0]  cls;
        logic [15:0] run;
        logic [7:0]  sw;
    } task_rec_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [7:0]       served_id;
        logic [15:0]      burned;
        logic [15:0]      remaining;
        logic             finished;
        logic [15:0]      run_total;
        logic [7:0]       switches;
        logic [OCC_W-1:0] occupancy;
    } result_t;

    typedef struct packed {
        logic [15:0] give;
        logic [15:0] new_rem;
        logic [15:0] total;
        logic        fin;
        logic [7:0]  sw;
    } slice_res_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_INSERT,
        ST_SLICE_RD,
        ST_SLICE_EX,
        ST_DONE
    } state_t;

endpackage

// File: src/wrrs_ram.sv
// Generic simple dual-port RAM with registered read.
module wrrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// File: src/wrrs_slice_alu.sv
// Slice arithmetic: weighted quantum, time given, saturating totals.
module wrrs_slice_alu (
    input  logic [15:0]           quantum,
    input  wrrs_pkg::task_rec_t   rec,
    output wrrs_pkg::slice_res_t  res
);
    import wrrs_pkg::*;

    logic [2:0]  weight;
    logic [18:0] slice_len;
    logic [16:0] run_sum;

    always_comb begin
        weight    = {1'b0, rec.cls} + 3'd1;
        slice_len = 19'(quantum) * 19'(weight);
        // slice no longer than the remaining time fits in 16 bits
        res.give    = (19'(rec.remaining) < slice_len) ? rec.remaining : slice_len[15:0];
        res.new_rem = rec.remaining - res.give;
        run_sum     = {1'b0, rec.run} + {1'b0, res.give};
        res.total   = run_sum[16] ? 16'hFFFF : run_sum[15:0];
        res.fin     = (res.new_rem == 16'd0);
        if (res.fin || rec.sw == 8'hFF) begin
            res.sw = rec.sw;
        end else begin
            res.sw = rec.sw + 8'd1;
        end
    end

endmodule

// File: src/wrrs_ctrl.sv
// Queue sequencer: circular record store, ordered insert, slice service.
module wrrs_ctrl #(
    parameter int QUEUE_DEPTH = wrrs_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [15:0]                    quantum,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  wrrs_pkg::item_t                s_item,
    output logic                           res_valid,
    input  logic                           res_ready,
    output wrrs_pkg::result_t              res,
    output logic                           wr_en,
    output logic [$clog2(QUEUE_DEPTH)-1:0] wr_addr,
    output wrrs_pkg::task_rec_t            wr_data,
    output logic [$clog2(QUEUE_DEPTH)-1:0] rd_addr,
    input  wrrs_pkg::task_rec_t            rd_data
);
    import wrrs_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = CW + 1;
    localparam logic [CW-1:0] DEPTH_C  = CW'(QUEUE_DEPTH);
    localparam logic [SW-1:0] DEPTH_SW = SW'(QUEUE_DEPTH);

    state_t          state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [AW-1:0]   head_reg, head_next;
    logic [CW-1:0]   idx_reg, idx_next;
    logic [CW-1:0]   pos_reg, pos_next;
    item_t           item_reg, item_next;
    result_t         res_reg, res_next;
    slice_res_t      slice;

    // queue position to RAM slot, wrapping once past the end
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                           input logic [CW-1:0] p);
        logic [SW-1:0] s;
        s = SW'(head) + SW'(p);
        if (s >= DEPTH_SW) begin
            s = s - DEPTH_SW;
        end
        return s[AW-1:0];
    endfunction

    wrrs_slice_alu u_alu (
        .quantum (quantum),
        .rec     (rd_data),
        .res     (slice)
    );

    assign res = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            head_reg  <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            head_reg  <= head_next;
        end
        idx_reg  <= idx_next;
        pos_reg  <= pos_next;
        item_reg <= item_next;
        res_reg  <= res_next;
    end

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        head_next  = head_reg;
        idx_next   = idx_reg;
        pos_next   = pos_reg;
        item_next  = item_reg;
        res_next   = res_reg;
        s_ready    = 1'b0;
        res_valid  = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = phys(head_reg, idx_reg);
        wr_data    = rd_data;
        rd_addr    = phys(head_reg, idx_reg);

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    item_next          = s_item;
                    res_next           = '0;
                    res_next.status    = STATUS_OK;
                    res_next.occupancy = OCC_W'(count_reg);
                    idx_next           = '0;
                    if (s_item.operation == OP_ADD) begin
                        if (count_reg == DEPTH_C) begin
                            res_next.status = STATUS_FULL;
                            state_next      = ST_DONE;
                        end else if (count_reg == '0) begin
                            pos_next   = '0;
                            state_next = ST_INSERT;
                        end else begin
                            state_next = ST_SCAN_RD;
                        end
                    end else begin
                        if (count_reg == '0) begin
                            res_next.status = STATUS_EMPTY;
                            state_next      = ST_DONE;
                        end else begin
                            state_next = ST_SLICE_RD;
                        end
                    end
                end
            end
            ST_SCAN_RD: begin
                state_next = ST_SCAN_CHK;
            end
            ST_SCAN_CHK: begin
                if (rd_data.arrival > item_reg.arrival) begin
                    pos_next   = idx_reg;
                    idx_next   = count_reg - CW'(1);
                    state_next = ST_SHIFT_RD;
                end else if (idx_reg + CW'(1) == count_reg) begin
                    pos_next   = count_reg;
                    state_next = ST_INSERT;
                end else begin
                    idx_next   = idx_reg + CW'(1);
                    state_next = ST_SCAN_RD;
                end
            end
            ST_SHIFT_RD: begin
                state_next = ST_SHIFT_WR;
            end
            ST_SHIFT_WR: begin
                wr_en   = 1'b1;
                wr_addr = phys(head_reg, idx_reg + CW'(1));
                wr_data = rd_data;
                if (idx_reg == pos_reg) begin
                    state_next = ST_INSERT;
                end else begin
                    idx_next   = idx_reg - CW'(1);
                    state_next = ST_SHIFT_RD;
                end
            end
            ST_INSERT: begin
                wr_en             = 1'b1;
                wr_addr           = phys(head_reg, pos_reg);
                wr_data.id        = item_reg.task_id;
                wr_data.arrival   = item_reg.arrival;
                wr_data.remaining = item_reg.burst;
                wr_data.cls       = item_reg.task_class;
                wr_data.run       = '0;
                wr_data.sw        = '0;
                count_next         = count_reg + CW'(1);
                res_next.occupancy = OCC_W'(count_reg + CW'(1));
                state_next         = ST_DONE;
            end
            ST_SLICE_RD: begin
                rd_addr    = head_reg;
                state_next = ST_SLICE_EX;
            end
            ST_SLICE_EX: begin
                res_next.served_id = rd_data.id;
                res_next.burned    = slice.give;
                res_next.remaining = slice.new_rem;
                res_next.finished  = slice.fin;
                res_next.run_total = slice.total;
                res_next.switches  = slice.sw;
                head_next          = phys(head_reg, CW'(1));
                if (slice.fin) begin
                    count_next         = count_reg - CW'(1);
                    res_next.occupancy = OCC_W'(count_reg - CW'(1));
                end else begin
                    // head record goes to the slot just past the tail
                    wr_en             = 1'b1;
                    wr_addr           = phys(head_reg, count_reg);
                    wr_data.remaining = slice.new_rem;
                    wr_data.run       = slice.total;
                    wr_data.sw        = slice.sw;
                    res_next.occupancy = OCC_W'(count_reg);
                end
                state_next = ST_DONE;
            end
            ST_DONE: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= DEPTH_C)
        else $error("queue count beyond depth");
    a_insert_room: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_INSERT |-> count_reg < DEPTH_C)
        else $error("insert into a full queue");
    a_shift_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SHIFT_WR |-> (idx_reg >= pos_reg && idx_reg < count_reg))
        else $error("shift index outside insert range");
    a_count_source: assert property (@(posedge aclk) disable iff (!aresetn)
        !$stable(count_reg) |->
            ($past(state_reg) == ST_INSERT || $past(state_reg) == ST_SLICE_EX))
        else $error("queue count changed outside insert or slice");
    a_idle_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE || state_reg == ST_DONE) |-> !wr_en)
        else $error("record write while not working on an item");
`endif

endmodule

// File: src/weighted_round_robin_scheduler_top.sv
// Top level of the weighted round-robin time-slice scheduler.
//
// Ready queue of up to QUEUE_DEPTH task records held in one RAM with a
// registered read, addressed as a circular buffer from a head
// pointer. An add transfer (operation 0) walks the queue from the head, one
// entry per read, to find the first task whose arrival is strictly later,
// moves the entries behind that point one slot towards the tail, newest
// first, and writes the new record in the gap; a full queue drops the task
// with status 1. A slice transfer (operation 1) reads the head task, serves
// it for min(remaining, quantum * (class + 1)), and either retires it or
// writes it back one slot past the tail; the head pointer simply advances.
// A slice on an empty queue returns status 2. Rate: one item at a time.
// Every search read and every move is one pass through the single RAM read
// port and waits on its registered read; full and empty cases go straight to
// the result. The result sits in an output register, so the next input is
// taken while a result still waits on m_ready. quantum is written through
// the cfg_ channel (always ready); the user must write it only while the block
// is idle, which the block itself does not enforce; it resets to 10.
// RAM contents need no clearing after reset: only occupied slots are read.
module weighted_round_robin_scheduler_top #(
    parameter int QUEUE_DEPTH = wrrs_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // configuration: quantum
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [15:0]                cfg_data,
    // input items
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_operation,
    input  logic [7:0]                 s_task_id,
    input  logic [15:0]                s_arrival,
    input  logic [15:0]                s_burst,
    input  logic [1:0]                 s_task_class,
    // results
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [1:0]                 m_status,
    output logic [7:0]                 m_served_id,
    output logic [15:0]                m_burned,
    output logic [15:0]                m_remaining,
    output logic                       m_finished,
    output logic [15:0]                m_run_total,
    output logic [7:0]                 m_switches,
    output logic [wrrs_pkg::OCC_W-1:0] m_occupancy
);
    import wrrs_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);

    logic [15:0] quantum_reg;
    logic        out_valid_reg;
    result_t     out_reg;

    item_t       s_item;
    logic        res_valid;
    logic        res_ready;
    result_t     res;

    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    task_rec_t       wr_data;
    logic [AW-1:0]   rd_addr;
    task_rec_t       rd_data;

    // Quantum register; the user must write it only while idle, as the block has no guard.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quantum_reg <= QUANTUM_RESET;
        end else if (cfg_valid) begin
            quantum_reg <= cfg_data;
        end
    end

    always_comb begin
        s_item.operation  = s_operation;
        s_item.task_id    = s_task_id;
        s_item.arrival    = s_arrival;
        s_item.burst      = s_burst;
        s_item.task_class = s_task_class;
    end

    wrrs_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .quantum   (quantum_reg),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

    // Task records, one slot per queue entry.
    wrrs_ram #(
        .WIDTH ($bits(task_rec_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_rec_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Output register: loads when empty or being drained this cycle.
    assign res_ready = !out_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (res_ready) begin
            out_valid_reg <= res_valid;
        end
        if (res_ready && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_status    = out_reg.status;
    assign m_served_id = out_reg.served_id;
    assign m_burned    = out_reg.burned;
    assign m_remaining = out_reg.remaining;
    assign m_finished  = out_reg.finished;
    assign m_run_total = out_reg.run_total;
    assign m_switches  = out_reg.switches;
    assign m_occupancy = out_reg.occupancy;

`ifndef SYNTHESIS
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(out_reg)))
        else $error("result changed before its transfer");
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res_ready) |=> m_valid)
        else $error("result lost on its way to the output register");
    a_quantum_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg_valid && cfg_ready) |=> quantum_reg == $past(cfg_data))
        else $error("quantum write not taken");
`endif

endmodule

// File: verif/weighted_round_robin_scheduler_top_tb.sv
// Self-checking testbench for the weighted round-robin scheduler: random stimulus with a predictor.
module weighted_round_robin_scheduler_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wrrs_pkg::*;

    localparam int          SCHED_DEPTH = 16;
    localparam int unsigned CYCLE_LIMIT = 250000;
    // Longest add walks and moves every entry; the drain wait covers it with margin.
    localparam int unsigned DRAIN_CYCLES = 2 * SCHED_DEPTH + 8;
    localparam int unsigned REPORT_CAP   = 100;
    localparam int unsigned DEEP_SLICES  = 270;

    // Task classes; three still weights as 4.
    localparam logic [1:0] CLASS_USER  = 2'd0;
    localparam logic [1:0] CLASS_MID   = 2'd1;
    localparam logic [1:0] CLASS_ADMIN = 2'd2;
    localparam logic [1:0] CLASS_OVER  = 2'd3;

    // One ready-queue entry as the predictor holds it, head at index 0.
    typedef struct {
        logic [7:0]  id;
        logic [15:0] arrival;
        logic [15:0] left;
        logic [1:0]  cls;
        logic [15:0] run;
        logic [7:0]  sw;
    } task_entry_t;

    // ------------------------------------------------------------------
    // Clock, reset and block ports; every input known from time zero
    // ------------------------------------------------------------------
    logic              aclk;
    logic              aresetn      = 1'b0;
    logic              cfg_valid    = 1'b0;
    logic              cfg_ready;
    logic [15:0]       cfg_data     = '0;
    logic              s_valid      = 1'b0;
    logic              s_ready;
    logic              s_operation  = OP_ADD;
    logic [7:0]        s_task_id    = '0;
    logic [15:0]       s_arrival    = '0;
    logic [15:0]       s_burst      = '0;
    logic [1:0]        s_task_class = CLASS_USER;
    logic              m_valid;
    logic              m_ready      = 1'b0;
    logic [1:0]        m_status;
    logic [7:0]        m_served_id;
    logic [15:0]       m_burned;
    logic [15:0]       m_remaining;
    logic              m_finished;
    logic [15:0]       m_run_total;
    logic [7:0]        m_switches;
    logic [OCC_W-1:0]  m_occupancy;

    weighted_round_robin_scheduler_top #(
        .QUEUE_DEPTH (SCHED_DEPTH)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_operation  (s_operation),
        .s_task_id    (s_task_id),
        .s_arrival    (s_arrival),
        .s_burst      (s_burst),
        .s_task_class (s_task_class),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_served_id  (m_served_id),
        .m_burned     (m_burned),
        .m_remaining  (m_remaining),
        .m_finished   (m_finished),
        .m_run_total  (m_run_total),
        .m_switches   (m_switches),
        .m_occupancy  (m_occupancy)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Predictor state: our own copy of the ready queue and of quantum
    // ------------------------------------------------------------------
    task_entry_t ready_list[$];
    logic [15:0] quantum_now = QUANTUM_RESET;

    item_t       stim_items[$];    // items waiting for the driver
    result_t     due_results[$];   // predicted results, oldest first

    int unsigned items_staged    = 0;
    int unsigned items_accepted  = 0;
    int unsigned results_checked = 0;
    int unsigned mismatch_count  = 0;
    int unsigned cycle_count     = 0;

    // Coverage tallies for the closing summary
    int unsigned adds_seen      = 0;
    int unsigned slices_seen    = 0;
    int unsigned full_drops     = 0;
    int unsigned empty_slices   = 0;
    int unsigned tasks_retired  = 0;
    int unsigned settings_used  = 0;
    int unsigned top_switches   = 0;

    // Works out the result of one item and moves the predicted queue on.
    function automatic result_t schedule_item(item_t it);
        result_t     r;
        task_entry_t t;
        int unsigned pos;
        int unsigned slice_len;
        int unsigned give;
        int unsigned total;
        r = '0;
        if (it.operation == OP_ADD) begin
            adds_seen++;
            if (ready_list.size() >= SCHED_DEPTH) begin
                // full queue: the task is dropped, nothing moves
                r.status = STATUS_FULL;
                full_drops++;
            end else begin
                // insert ahead of the first strictly later arrival, so ties keep load order
                pos = 0;
                while (pos < ready_list.size() && ready_list[pos].arrival <= it.arrival)
                    pos++;
                t.id      = it.task_id;
                t.arrival = it.arrival;
                t.left    = it.burst;
                t.cls     = it.task_class;
                t.run     = '0;
                t.sw      = '0;
                ready_list.insert(pos, t);
                r.status = STATUS_OK;
            end
        end else begin
            slices_seen++;
            if (ready_list.size() == 0) begin
                r.status = STATUS_EMPTY;
                empty_slices++;
            end else begin
                t = ready_list.pop_front();
                slice_len = 32'(quantum_now) * (32'(t.cls) + 32'd1);
                give      = (32'(t.left) < slice_len) ? 32'(t.left) : slice_len;
                total     = 32'(t.run) + give;
                if (total > 32'hFFFF)
                    total = 32'hFFFF;
                t.left = t.left - 16'(give);
                t.run  = 16'(total);
                r.status    = STATUS_OK;
                r.served_id = t.id;
                r.burned    = 16'(give);
                r.remaining = t.left;
                r.run_total = t.run;
                if (t.left == 0) begin
                    // done: retired, switch count reported as it stood
                    r.finished = 1'b1;
                    r.switches = t.sw;
                    tasks_retired++;
                end else begin
                    // preempted: count saturates, task goes to the tail
                    if (t.sw != 8'hFF)
                        t.sw++;
                    r.switches = t.sw;
                    ready_list.push_back(t);
                end
                if (32'(r.switches) > top_switches)
                    top_switches = 32'(r.switches);
            end
        end
        r.occupancy = OCC_W'(ready_list.size());
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------
    // Per-item wait of one side: mostly 0..12, with stretches of no idling.
    function automatic int unsigned draw_wait(inout int unsigned calm);
        if (calm != 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0) begin
            calm = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 12);
    endfunction

    function automatic item_t make_item(logic op, logic [7:0] id, logic [15:0] arr,
                                        logic [15:0] burst, logic [1:0] cls);
        item_t it;
        it.operation  = op;
        it.task_id    = id;
        it.arrival    = arr;
        it.burst      = burst;
        it.task_class = cls;
        return it;
    endfunction

    // One line per mismatch, capped so a badly broken block cannot flood the log.
    task automatic report_mismatch(string what);
        if (mismatch_count < REPORT_CAP)
            $display("[%0t] mismatch on result %0d: %s", $realtime, results_checked, what);
        mismatch_count++;
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    task automatic stage(item_t it);
        stim_items.push_back(it);
        items_staged++;
    endtask

    // Idle means every staged item accepted and every predicted result transferred.
    task automatic wait_idle();
        do @(posedge aclk);
        while (items_accepted != items_staged || results_checked != items_accepted);
    endtask

    // Quantum is written only while idle, so the predictor copy changes at the same transfer.
    task automatic write_quantum(logic [15:0] value);
        @(posedge aclk);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid   <= 1'b0;
        quantum_now = value;
        settings_used++;
    endtask

    // Random traffic: add_pct sets the add/slice mix and so how full the queue runs.
    task automatic stage_random(int unsigned count, int unsigned add_pct);
        item_t it;
        for (int unsigned n = 0; n < count; n++) begin
            it.operation = ($urandom_range(0, 99) < add_pct) ? OP_ADD : OP_SLICE;
            it.task_id   = 8'($urandom_range(0, 255));
            case ($urandom_range(0, 7))
                0:       it.arrival = 16'h0000;
                1:       it.arrival = 16'hFFFF;
                2, 3:    it.arrival = 16'($urandom_range(0, 65535));
                default: it.arrival = 16'($urandom_range(0, 15));  // plenty of ties
            endcase
            case ($urandom_range(0, 15))
                0:       it.burst = 16'h0000;
                1:       it.burst = 16'hFFFF;
                2, 3:    it.burst = 16'($urandom_range(0, 65535));
                4, 5, 6: it.burst = 16'($urandom_range(1, 2000));
                default: it.burst = 16'($urandom_range(1, 40));
            endcase
            it.task_class = ($urandom_range(0, 9) == 0) ? CLASS_OVER
                                                        : 2'($urandom_range(0, 2));
            stage(it);
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: one transfer at a time from stim_items, random gap before each
    // ------------------------------------------------------------------
    item_t       cur_item;
    logic        drv_valid;
    int unsigned src_gap  = 0;
    int unsigned src_calm = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            drv_valid = s_valid;
            if (s_valid && s_ready) begin
                due_results.push_back(schedule_item(cur_item));
                items_accepted++;
                drv_valid = 1'b0;
                src_gap   = draw_wait(src_calm);
            end
            if (!drv_valid) begin
                if (src_gap != 0) begin
                    src_gap--;
                end else if (stim_items.size() != 0) begin
                    cur_item     = stim_items.pop_front();
                    drv_valid    = 1'b1;
                    s_operation  <= cur_item.operation;
                    s_task_id    <= cur_item.task_id;
                    s_arrival    <= cur_item.arrival;
                    s_burst      <= cur_item.burst;
                    s_task_class <= cur_item.task_class;
                end
            end
            // single assignment per edge: a back-to-back transfer keeps valid high
            s_valid <= drv_valid;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: random back-pressure, each result checked against the oldest prediction
    // ------------------------------------------------------------------
    result_t     want;
    int unsigned sink_gap  = 0;
    int unsigned sink_calm = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (due_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result, status %0d id %0d",
                                              m_status, m_served_id));
                end else begin
                    want = due_results.pop_front();
                    check_field("status",    32'(m_status),    32'(want.status));
                    check_field("served_id", 32'(m_served_id), 32'(want.served_id));
                    check_field("burned",    32'(m_burned),    32'(want.burned));
                    check_field("remaining", 32'(m_remaining), 32'(want.remaining));
                    check_field("finished",  32'(m_finished),  32'(want.finished));
                    check_field("run_total", 32'(m_run_total), 32'(want.run_total));
                    check_field("switches",  32'(m_switches),  32'(want.switches));
                    check_field("occupancy", 32'(m_occupancy), 32'(want.occupancy));
                end
                results_checked++;
                sink_gap = draw_wait(sink_calm);
            end
            if (sink_gap != 0) begin
                sink_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------
    always @(posedge aclk)
        cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d of %0d items accepted, %0d results",
                 cycle_count, items_accepted, items_staged, results_checked);
        $display("FAILED: results differ");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sequence of phases
    // ------------------------------------------------------------------
    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part, quantum at its reset value of 10.
        stage(make_item(OP_SLICE, 8'h77, 16'h1234, 16'h4321, CLASS_ADMIN)); // empty queue
        stage(make_item(OP_ADD, 8'h00, 16'h0000, 16'h0000, CLASS_USER));    // zero burst
        stage(make_item(OP_ADD, 8'hFF, 16'hFFFF, 16'hFFFF, CLASS_ADMIN));   // all-ones fields
        stage(make_item(OP_ADD, 8'h5A, 16'd100, 16'd25, CLASS_MID));
        stage(make_item(OP_ADD, 8'hA5, 16'd100, 16'd5, CLASS_OVER));        // tie, class three
        stage(make_item(OP_ADD, 8'h3C, 16'd100, 16'd1, CLASS_USER));        // second tie
        stage(make_item(OP_SLICE, 8'h00, 16'h0000, 16'h0000, CLASS_USER));  // zero burst retires
        stage(make_item(OP_SLICE, 8'h00, 16'h0000, 16'h0000, CLASS_USER));  // partial, rotates
        stage(make_item(OP_SLICE, 8'h00, 16'h0000, 16'h0000, CLASS_USER));  // weight four
        // fill to the brim with ties at the top of the key range
        for (int unsigned k = 1; k <= 13; k++)
            stage(make_item(OP_ADD, 8'(k), (k % 3 == 0) ? 16'hFFFF : 16'(k * 37),
                            16'(k * 3), 2'(k % 4)));
        stage(make_item(OP_ADD, 8'hEE, 16'd50, 16'd9, CLASS_MID));          // full, dropped
        stage(make_item(OP_SLICE, 8'hFF, 16'hFFFF, 16'hFFFF, CLASS_OVER));
        stage(make_item(OP_ADD, 8'hEE, 16'd50, 16'd9, CLASS_MID));          // room again
        wait_idle();

        // Largest quantum: every slice retires its task, then drain the queue.
        write_quantum(16'hFFFF);
        stage_random(60, 60);
        wait_idle();
        for (int unsigned k = ready_list.size(); k != 0; k--)
            stage(make_item(OP_SLICE, 8'($urandom_range(0, 255)), 16'h0, 16'h0, CLASS_USER));
        wait_idle();

        // Smallest quantum on one long task: the switch count must saturate.
        write_quantum(16'd1);
        stage(make_item(OP_ADD, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                        16'hFFFF, CLASS_USER));
        for (int unsigned k = 0; k < DEEP_SLICES; k++)
            stage(make_item(OP_SLICE, 8'($urandom_range(0, 255)),
                            16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                            2'($urandom_range(0, 3))));
        wait_idle();

        // Zero quantum: nothing is served, only zero-burst tasks leave.
        write_quantum(16'd0);
        stage_random(40, 50);
        wait_idle();

        write_quantum(16'($urandom_range(2, 30)));
        stage_random(90, 65);
        wait_idle();

        write_quantum(16'($urandom_range(31, 3000)));
        stage_random(90, 45);
        wait_idle();

        write_quantum(QUANTUM_RESET);
        stage_random(70, 55);
        wait_idle();

        // Anything the block still had in hand would show up here as unexpected.
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (due_results.size() != 0)
            report_mismatch($sformatf("%0d predicted results never arrived",
                                      due_results.size()));

        $display("covered %0d items: %0d adds (%0d dropped on a full queue), %0d slices",
                 items_accepted, adds_seen, full_drops, slices_seen);
        $display("  %0d on an empty queue, %0d tasks retired, peak switch count %0d, %0d quanta",
                 empty_slices, tasks_retired, top_switches, settings_used);
        if (mismatch_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
